// ----- src/lru_buffer_pool_with_pinning_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the buffer pool replacement block
// ---------------------------------------------------------------------------
`ifndef LRU_BUFFER_POOL_WITH_PINNING_MACROS_SVH
`define LRU_BUFFER_POOL_WITH_PINNING_MACROS_SVH

// implication checked on every edge outside reset
`define LBP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define LBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/lbp_pkg.sv -----
// ---------------------------------------------------------------------------
// lbp_pkg
// Types and constants shared by the buffer pool replacement block.
// ---------------------------------------------------------------------------
package lbp_pkg;

    localparam int CAPACITY   = 64;
    localparam int FILE_BITS  = 8;
    localparam int BLOCK_BITS = 20;
    localparam int SLOT_BITS  = 6;
    localparam int CNT_BITS   = 7;

    localparam logic [1:0] FUNC_ACCESS = 2'd0;
    localparam logic [1:0] FUNC_DROP   = 2'd1;
    localparam logic [1:0] FUNC_FLAGS  = 2'd2;

    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_WBACK = 2'd1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_ABSENT  = 2'd1;
    localparam logic [1:0] STAT_PINNED  = 2'd2;

    typedef struct packed {
        logic [1:0]            func;
        logic [FILE_BITS-1:0]  file_id;
        logic [BLOCK_BITS-1:0] block_id;
        logic                  pin_value;
        logic                  dirty_value;
    } req_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [SLOT_BITS-1:0]  slot;
        logic [FILE_BITS-1:0]  out_file;
        logic [BLOCK_BITS-1:0] out_block;
        logic                  hit;
        logic [1:0]            status;
        logic                  last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_WBACK,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic commit;
        logic emit_wb;
        logic emit_done;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic need_wb;
        logic ignore;
    } sts_t;

endpackage

// ----- src/lru_buffer_pool_with_pinning.sv -----
// ---------------------------------------------------------------------------
// lru_buffer_pool_with_pinning
// LRU replacement of a 64-slot buffer pool with pin and dirty marks.
// ---------------------------------------------------------------------------
// Result beats are registered after the look-up state; a write-back beat is
// followed by the completion beat in the next cycle.
// A new request is taken only in the idle state; busy stays high through the
// look-up and write-back states of the sequencer.
// Reset: asynchronous, clears all slot valid and mark bits; no sweep needed.
// Result beats cannot be stalled by the receiver.
module lru_buffer_pool_with_pinning (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  lbp_pkg::req_t   req,
    output logic            busy,
    output logic            result_valid,
    output lbp_pkg::rsp_t   result
);

    lbp_pkg::ctl_t ctl;
    lbp_pkg::sts_t sts;

    // sequencer
    lbp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    // slot state and matching
    lbp_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .ctl          (ctl),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- src/lbp_ctrl.sv -----
// ---------------------------------------------------------------------------
// lbp_ctrl
// Sequencer: capture, look-up, optional write-back beat, completion beat.
// ---------------------------------------------------------------------------
module lbp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  lbp_pkg::sts_t   sts,
    output lbp_pkg::ctl_t   ctl,
    output logic            busy
);

    lbp_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lbp_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lbp_pkg::ST_IDLE:  if (start) state_next = lbp_pkg::ST_LOOK;
            lbp_pkg::ST_LOOK:
                if (sts.ignore)       state_next = lbp_pkg::ST_IDLE;
                else if (sts.need_wb) state_next = lbp_pkg::ST_WBACK;
                else                  state_next = lbp_pkg::ST_IDLE;
            lbp_pkg::ST_WBACK: state_next = lbp_pkg::ST_IDLE;
            default:           state_next = lbp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl  = '0;
        busy = 1'b1;
        unique case (state_reg)
            lbp_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                ctl.load = start;
            end
            lbp_pkg::ST_LOOK:
            begin
                ctl.commit    = !sts.ignore;
                ctl.emit_wb   = !sts.ignore && sts.need_wb;
                ctl.emit_done = !sts.ignore && !sts.need_wb;
            end
            lbp_pkg::ST_WBACK: ctl.emit_done = 1'b1;
            default:           ctl = '0;
        endcase
    end

endmodule

// ----- src/lbp_datapath.sv -----
// ---------------------------------------------------------------------------
// lbp_datapath
// Slot tags, marks and recency ranks with parallel match and rank update.
// ---------------------------------------------------------------------------
`include "lru_buffer_pool_with_pinning_macros.svh"

module lbp_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  lbp_pkg::req_t   req,
    input  lbp_pkg::ctl_t   ctl,
    output lbp_pkg::sts_t   sts,
    output logic            result_valid,
    output lbp_pkg::rsp_t   result
);

    localparam int N = lbp_pkg::CAPACITY;
    localparam int SB = lbp_pkg::SLOT_BITS;

    lbp_pkg::req_t                    req_reg;
    logic [N-1:0]                     valid_reg, pin_reg, dirty_reg;
    logic [lbp_pkg::FILE_BITS-1:0]    ftag_reg [N];
    logic [lbp_pkg::BLOCK_BITS-1:0]   btag_reg [N];
    logic [SB-1:0]                    rank_reg [N];
    logic [lbp_pkg::CNT_BITS-1:0]     count_reg;
    logic                             res_v_reg;
    lbp_pkg::rsp_t                    res_reg, done_reg;

    // look-up
    logic [N-1:0] match, fmatch, cand, vict_hot;
    logic         hit_any, full, vict_any, free_any;
    logic [SB-1:0] hit_s, vict_s, free_s, hit_rank, vict_rank, new_s;
    logic [N-1:0] valid_after;
    logic [SB-1:0] drop_rank [N];
    logic [N-1:0]  below [N];

    always_comb
    begin
        hit_any = 1'b0; hit_s = '0; hit_rank = '0;
        free_any = 1'b0; free_s = '0;
        for (int i = 0; i < N; i++)
        begin
            fmatch[i] = valid_reg[i] && ftag_reg[i] == req_reg.file_id;
            match[i]  = fmatch[i] && btag_reg[i] == req_reg.block_id;
            cand[i]   = valid_reg[i] && !pin_reg[i];
            if (match[i] && !hit_any)
            begin
                hit_any = 1'b1; hit_s = SB'(i); hit_rank = rank_reg[i];
            end
            if (!valid_reg[i] && !free_any)
            begin
                free_any = 1'b1; free_s = SB'(i);
            end
        end
        // oldest unpinned slot: the candidate that no other candidate outranks;
        // ranks of valid slots are distinct, so at most one is marked
        vict_any = |cand;
        vict_s = '0; vict_rank = '0;
        for (int i = 0; i < N; i++)
        begin
            vict_hot[i] = cand[i];
            for (int j = 0; j < N; j++)
                if (cand[j] && rank_reg[j] > rank_reg[i])
                    vict_hot[i] = 1'b0;
        end
        for (int i = 0; i < N; i++)
            if (vict_hot[i])
            begin
                vict_s = SB'(i); vict_rank = rank_reg[i];
            end
        full = count_reg >= lbp_pkg::CNT_BITS'(N);
    end

    always_comb
    begin
        sts.ignore  = req_reg.func != lbp_pkg::FUNC_ACCESS &&
                      req_reg.func != lbp_pkg::FUNC_DROP &&
                      req_reg.func != lbp_pkg::FUNC_FLAGS;
        sts.need_wb = req_reg.func == lbp_pkg::FUNC_ACCESS && !hit_any && full &&
                      vict_any && dirty_reg[vict_s];
        new_s = full ? vict_s : free_s;
    end

    lbp_pkg::rsp_t wb_rsp, done_rsp;
    logic do_insert;

    always_comb
    begin
        wb_rsp = '0;
        wb_rsp.kind      = lbp_pkg::KIND_WBACK;
        wb_rsp.slot      = vict_s;
        wb_rsp.out_file  = ftag_reg[vict_s];
        wb_rsp.out_block = btag_reg[vict_s];
        done_rsp = '0;
        done_rsp.kind      = lbp_pkg::KIND_DONE;
        done_rsp.last      = 1'b1;
        done_rsp.out_file  = req_reg.file_id;
        done_rsp.out_block = req_reg.block_id;
        do_insert = 1'b0;
        case (req_reg.func)
            lbp_pkg::FUNC_ACCESS:
                if (hit_any)
                begin
                    done_rsp.slot = hit_s; done_rsp.hit = 1'b1;
                end
                else if (full && !vict_any)
                    done_rsp.status = lbp_pkg::STAT_PINNED;
                else if (!full && !free_any)
                    done_rsp.status = lbp_pkg::STAT_PINNED;
                else
                begin
                    done_rsp.slot = new_s; do_insert = 1'b1;
                end
            lbp_pkg::FUNC_DROP:
                done_rsp.out_block = '0;
            default:
                if (hit_any)
                begin
                    done_rsp.slot = hit_s; done_rsp.hit = 1'b1;
                end
                else
                    done_rsp.status = lbp_pkg::STAT_ABSENT;
        endcase
    end

    // compacted ranks after a drop: count surviving slots of lower rank
    always_comb
    begin
        for (int i = 0; i < N; i++)
            valid_after[i] = valid_reg[i] && !fmatch[i];
        for (int i = 0; i < N; i++)
        begin
            for (int j = 0; j < N; j++)
                below[i][j] = valid_after[j] && rank_reg[j] < rank_reg[i];
            drop_rank[i] = SB'($countones(below[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            req_reg <= req;
        if (ctl.commit)
            done_reg <= done_rsp;
        if (ctl.emit_wb)
            res_reg <= wb_rsp;
        else if (ctl.emit_done)
            res_reg <= ctl.commit ? done_rsp : done_reg;
        if (ctl.commit && do_insert)
        begin
            ftag_reg[new_s] <= req_reg.file_id;
            btag_reg[new_s] <= req_reg.block_id;
        end
        // rank update: evict+insert at full pool = promote new slot from old rank
        if (ctl.commit)
            for (int i = 0; i < N; i++)
            begin
                if (req_reg.func == lbp_pkg::FUNC_ACCESS && hit_any)
                begin
                    if (SB'(i) == hit_s) rank_reg[i] <= '0;
                    else if (valid_reg[i] && rank_reg[i] < hit_rank)
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                end
                else if (do_insert)
                begin
                    if (SB'(i) == new_s) rank_reg[i] <= '0;
                    else if (valid_reg[i] && (!full || rank_reg[i] < vict_rank))
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                end
                else if (req_reg.func == lbp_pkg::FUNC_DROP && valid_after[i])
                    rank_reg[i] <= drop_rank[i];
            end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0; pin_reg <= '0; dirty_reg <= '0;
            count_reg <= '0; res_v_reg <= 1'b0;
        end
        else
        begin
            res_v_reg <= ctl.emit_wb || ctl.emit_done;
            if (ctl.commit)
                case (req_reg.func)
                    lbp_pkg::FUNC_ACCESS:
                        if (do_insert)
                        begin
                            valid_reg[new_s] <= 1'b1;
                            pin_reg[new_s]   <= 1'b0;
                            dirty_reg[new_s] <= 1'b0;
                            if (!full) count_reg <= count_reg + 1'b1;
                        end
                    lbp_pkg::FUNC_DROP:
                    begin
                        valid_reg <= valid_after;
                        pin_reg   <= pin_reg & valid_after;
                        dirty_reg <= dirty_reg & valid_after;
                        count_reg <= lbp_pkg::CNT_BITS'($countones(valid_after));
                    end
                    default:
                        if (hit_any)
                        begin
                            pin_reg[hit_s]   <= req_reg.pin_value;
                            dirty_reg[hit_s] <= req_reg.dirty_value;
                        end
                endcase
        end
    end

    assign result_valid = res_v_reg;
    assign result       = res_reg;

    `LBP_ASSERT_IMP(a_count_le_cap, 1'b1, count_reg <= lbp_pkg::CNT_BITS'(N))
    `LBP_ASSERT_NEXT(a_wb_then_done, ctl.emit_wb, result_valid && !result.last)
    `LBP_ASSERT_IMP(a_count_ones, 1'b1, count_reg == lbp_pkg::CNT_BITS'($countones(valid_reg)))

endmodule

// ----- sim/lbp_checker.sv -----
// ---------------------------------------------------------------------------
// lbp_checker
// Watches request and result beats of the buffer pool block, keeps its own
// model of slot tags, marks and recency, and compares every result beat.
// ---------------------------------------------------------------------------
module lbp_checker
    import lbp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  busy,
    input  req_t  req,
    input  logic  result_valid,
    input  rsp_t  result,
    output int    fail_count,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic                  slot_used [CAPACITY];
    logic [FILE_BITS-1:0]  slot_file [CAPACITY];
    logic [BLOCK_BITS-1:0] slot_block[CAPACITY];
    logic                  slot_pin  [CAPACITY];
    logic                  slot_dirty[CAPACITY];
    int                    slot_rank [CAPACITY];
    int                    used_count;
    rsp_t                  awaited[$];

    assign pending = awaited.size();

    function automatic rsp_t mk(logic [1:0] k, int s, logic [FILE_BITS-1:0] f,
                                logic [BLOCK_BITS-1:0] b, logic h, logic [1:0] st,
                                logic l);
        rsp_t r;
        r.kind = k; r.slot = s[SLOT_BITS-1:0]; r.out_file = f; r.out_block = b;
        r.hit = h; r.status = st; r.last = l;
        return r;
    endfunction

    function automatic int lookup(logic [FILE_BITS-1:0] f, logic [BLOCK_BITS-1:0] b);
        for (int i = 0; i < CAPACITY; i++)
            if (slot_used[i] && slot_file[i] == f && slot_block[i] == b)
                return i;
        return -1;
    endfunction

    // bring slot s to the front, ageing every slot more recent than lim
    function automatic void to_front(int s, int lim);
        for (int i = 0; i < CAPACITY; i++)
            if (slot_used[i] && i != s && slot_rank[i] < lim)
                slot_rank[i] = slot_rank[i] + 1;
        slot_rank[s] = 0;
    endfunction

    function automatic void renumber();
        int nr[CAPACITY];
        for (int i = 0; i < CAPACITY; i++)
        begin
            nr[i] = 0;
            if (slot_used[i])
                for (int j = 0; j < CAPACITY; j++)
                    if (slot_used[j] && slot_rank[j] < slot_rank[i])
                        nr[i]++;
        end
        for (int i = 0; i < CAPACITY; i++)
            if (slot_used[i])
                slot_rank[i] = nr[i];
    endfunction

    function automatic void predict_pool(req_t q);
        int s;
        int victim;
        s = -1;
        victim = -1;
        if (q.func == FUNC_ACCESS)
        begin
            s = lookup(q.file_id, q.block_id);
            if (s >= 0)
            begin
                to_front(s, slot_rank[s]);
                awaited.push_back(mk(KIND_DONE, s, q.file_id, q.block_id, 1'b1,
                                     STAT_OK, 1'b1));
                return;
            end
            if (used_count >= CAPACITY)
            begin
                for (int i = 0; i < CAPACITY; i++)
                    if (slot_used[i] && !slot_pin[i] &&
                        (victim < 0 || slot_rank[i] > slot_rank[victim]))
                        victim = i;
                if (victim < 0)
                begin
                    awaited.push_back(mk(KIND_DONE, 0, q.file_id, q.block_id, 1'b0,
                                         STAT_PINNED, 1'b1));
                    return;
                end
                if (slot_dirty[victim])
                    awaited.push_back(mk(KIND_WBACK, victim, slot_file[victim],
                                         slot_block[victim], 1'b0, STAT_OK, 1'b0));
                slot_used[victim] = 1'b0;
                renumber();
                used_count--;
            end
            s = -1;
            for (int i = 0; i < CAPACITY; i++)
                if (!slot_used[i] && s < 0)
                    s = i;
            to_front(s, CAPACITY);
            slot_used[s] = 1'b1;
            slot_file[s] = q.file_id;
            slot_block[s] = q.block_id;
            slot_pin[s] = 1'b0;
            slot_dirty[s] = 1'b0;
            used_count++;
            awaited.push_back(mk(KIND_DONE, s, q.file_id, q.block_id, 1'b0,
                                 STAT_OK, 1'b1));
        end
        else if (q.func == FUNC_DROP)
        begin
            for (int i = 0; i < CAPACITY; i++)
                if (slot_used[i] && slot_file[i] == q.file_id)
                begin
                    slot_used[i] = 1'b0;
                    slot_pin[i] = 1'b0;
                    slot_dirty[i] = 1'b0;
                    used_count--;
                end
            renumber();
            awaited.push_back(mk(KIND_DONE, 0, q.file_id, '0, 1'b0, STAT_OK, 1'b1));
        end
        else if (q.func == FUNC_FLAGS)
        begin
            s = lookup(q.file_id, q.block_id);
            if (s < 0)
                awaited.push_back(mk(KIND_DONE, 0, q.file_id, q.block_id, 1'b0,
                                     STAT_ABSENT, 1'b1));
            else
            begin
                slot_pin[s] = q.pin_value;
                slot_dirty[s] = q.dirty_value;
                awaited.push_back(mk(KIND_DONE, s, q.file_id, q.block_id, 1'b1,
                                     STAT_OK, 1'b1));
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                slot_used[i] = 1'b0;
                slot_pin[i] = 1'b0;
                slot_dirty[i] = 1'b0;
                slot_rank[i] = 0;
            end
            used_count = 0;
            fail_count = 0;
            awaited.delete();
        end
        else
        begin
            // result beat first: it cannot belong to a request taken this edge
            if (result_valid)
            begin
                if (awaited.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat %p", result);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (result !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: expected %p got %p", want, result);
                    end
                end
            end
            if (start && !busy)
                predict_pool(req);
        end
    end
endmodule

// ----- sim/lru_buffer_pool_with_pinning_tb.sv -----
// ---------------------------------------------------------------------------
// lru_buffer_pool_with_pinning_tb
// Drives access, drop, flag and unused-function beats into the buffer pool, with directed
// corner cases and then random traffic over a small set of files and blocks.
// ---------------------------------------------------------------------------
module lru_buffer_pool_with_pinning_tb;
    import lbp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic result_valid;
    rsp_t result;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    int   beats_in = 0;

    // watchdog: cycles with no beat accepted on either side
    localparam int STALL_LIMIT = 2000;

    always #5 clk = ~clk;

    lru_buffer_pool_with_pinning dut (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req),
        .busy(busy), .result_valid(result_valid), .result(result)
    );

    lbp_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .result_valid(result_valid), .result(result),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("lru_buffer_pool_with_pinning_tb: errors");
            $finish;
        end
    end

    // one request beat; start stays high across back-to-back beats
    task automatic issue(logic [1:0] fn, logic [FILE_BITS-1:0] f,
                         logic [BLOCK_BITS-1:0] b, logic p, logic d, bit gaps);
        req_t q;
        q.func = fn; q.file_id = f; q.block_id = b; q.pin_value = p; q.dirty_value = d;
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        req <= q;
        do @(posedge clk); while (busy);
        beats_in++;
    endtask

    // file and block drawn from a narrow pool so hits, evictions and drops recur
    task automatic random_beat(bit gaps);
        int sel;
        logic [FILE_BITS-1:0] f;
        logic [BLOCK_BITS-1:0] b;
        sel = $urandom_range(0, 99);
        f = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        b = ($urandom_range(0, 19) == 0) ? 20'($urandom) : 20'($urandom_range(0, 23));
        if (sel < 65)
            issue(FUNC_ACCESS, f, b, 1'($urandom), 1'($urandom), gaps);
        else if (sel < 92)
            issue(FUNC_FLAGS, f, b, ($urandom_range(0, 3) == 0), 1'($urandom), gaps);
        else if (sel < 97)
            issue(FUNC_DROP, f, 20'($urandom), 1'($urandom), 1'($urandom), gaps);
        else
            issue(2'd3, f, b, 1'($urandom), 1'($urandom), gaps);
    endtask

    initial
    begin
        int limit;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes: miss, hit, flags on absent and present, unused function, drop
        issue(FUNC_ACCESS, 8'hFF, 20'hFFFFF, 1'b0, 1'b0, 1'b0);
        issue(FUNC_ACCESS, 8'h00, 20'h00000, 1'b0, 1'b0, 1'b0);
        issue(FUNC_ACCESS, 8'hFF, 20'hFFFFF, 1'b0, 1'b0, 1'b0);
        issue(FUNC_FLAGS,  8'h55, 20'hAAAAA, 1'b1, 1'b1, 1'b0);
        issue(FUNC_FLAGS,  8'hFF, 20'hFFFFF, 1'b1, 1'b1, 1'b0);
        issue(FUNC_FLAGS,  8'hFF, 20'hFFFFF, 1'b0, 1'b1, 1'b0);
        issue(2'd3,        8'hAA, 20'h55555, 1'b1, 1'b1, 1'b0);
        issue(FUNC_DROP,   8'hFF, 20'hFFFFF, 1'b0, 1'b0, 1'b0);
        issue(FUNC_DROP,   8'h00, 20'h00000, 1'b0, 1'b0, 1'b0);

        // fill the pool, make all dirty, evict with write-back
        for (int i = 0; i < CAPACITY; i++)
            issue(FUNC_ACCESS, 8'd7, 20'(i), 1'b0, 1'b0, 1'b1);
        for (int i = 0; i < CAPACITY; i++)
            issue(FUNC_FLAGS, 8'd7, 20'(i), 1'b0, 1'b1, 1'b1);
        issue(FUNC_ACCESS, 8'd8, 20'd0, 1'b0, 1'b0, 1'b0);
        // pin everything: next miss reports all slots pinned
        for (int i = 0; i < CAPACITY; i++)
            issue(FUNC_FLAGS, 8'd7, 20'(i), 1'b1, 1'b0, 1'b1);
        issue(FUNC_FLAGS, 8'd8, 20'd0, 1'b1, 1'b1, 1'b0);
        issue(FUNC_ACCESS, 8'd9, 20'd9, 1'b0, 1'b0, 1'b0);
        issue(FUNC_DROP, 8'd7, 20'd0, 1'b0, 1'b0, 1'b0);
        issue(FUNC_DROP, 8'd8, 20'd0, 1'b0, 1'b0, 1'b0);

        // random traffic; tail end runs without gaps
        for (int n = 0; n < 620; n++)
        begin
            // now and then flood with misses so the pool stays near full
            if ($urandom_range(0, 149) == 0)
                for (int k = 0; k < 30; k++)
                    issue(FUNC_ACCESS, 8'($urandom_range(0, 5)),
                          20'($urandom_range(0, 200)), 1'b0, 1'b0, n < 500);
            random_beat(n < 500);
        end
        start <= 1'b0;

        limit = 0;
        while (pending != 0 && limit < STALL_LIMIT)
        begin
            @(posedge clk);
            limit++;
        end
        repeat (10) @(posedge clk);
        if (pending == 0 && fail_count == 0)
            $display("lru_buffer_pool_with_pinning_tb: clean");
        else
            $display("lru_buffer_pool_with_pinning_tb: errors");
        $finish;
    end
endmodule
